// ===== rtl/stws_pkg.sv =====
// Package for the weighted-selection sum tree.
// Holds sizes, item kind codes and the controller/datapath command and status words.
// No dependencies.
package stws_pkg;

    // Tree geometry.
    localparam int MAX_LEAVES = 1024;
    localparam int LEVEL_MAX  = $clog2(MAX_LEAVES);
    localparam int TREE_DEPTH = 2 * MAX_LEAVES;
    localparam int ADDR_W     = $clog2(TREE_DEPTH);

    // Field widths.
    localparam int KIND_W  = 2;
    localparam int LEAF_W  = 10;
    localparam int RANK_W  = 32;
    localparam int AMT_W   = 16;
    localparam int DATA_W  = 32;
    localparam int LVL_W   = 4;
    localparam int PASS_W  = 37;

    // Item kinds; the fourth code does nothing but report the total.
    localparam logic [KIND_W-1:0] KIND_ADD   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TAKE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic step;
        logic sweep;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic l_zero;
        logic walk_last;
        logic sweep_last;
    } t_dp_sts;

endpackage

// ===== rtl/stws_ctrl.sv =====
// Controller state machine for the weighted-selection sum tree.
// Depends on stws_pkg for the command and status words and the kind codes.
module stws_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    input  logic [stws_pkg::KIND_W-1:0]   i_kind,
    input  stws_pkg::t_dp_sts             i_sts,
    output stws_pkg::t_dp_cmd             o_cmd,
    output logic                          busy,
    output logic                          o_done
);
    import stws_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_WALK  = 5'b00010,
        ST_DONE  = 5'b00100,
        ST_CLEAR = 5'b01000,
        ST_INIT  = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and datapath commands.
    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    o_cmd.accept = 1'b1;
                    if (i_kind == KIND_CLEAR) begin
                        n_state = ST_CLEAR;
                    end else if ((i_kind == KIND_ADD || i_kind == KIND_TAKE) &&
                                 !i_sts.l_zero) begin
                        n_state = ST_WALK;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_WALK: begin
                o_cmd.step = 1'b1;
                if (i_sts.walk_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_CLEAR: begin
                o_cmd.sweep = 1'b1;
                if (i_sts.sweep_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_INIT: begin
                o_cmd.sweep = 1'b1;
                if (i_sts.sweep_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_DONE: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_INIT;
            end
        endcase
    end

    // State register; reset starts the zeroing pass over the memory.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy   = (r_state != ST_IDLE);
    assign o_done = (r_state == ST_DONE);

endmodule

// ===== rtl/stws_datapath.sv =====
// Datapath for the weighted-selection sum tree: node memory, walk registers, root total.
// Depends on stws_pkg for sizes, kind codes and the command and status words.
module stws_datapath (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  stws_pkg::t_dp_cmd                    i_cmd,
    output stws_pkg::t_dp_sts                    o_sts,
    input  logic                                 i_cfg_we,
    input  logic [stws_pkg::LVL_W-1:0]           i_cfg_wdata,
    input  logic [stws_pkg::KIND_W-1:0]          i_kind,
    input  logic [stws_pkg::LEAF_W-1:0]          i_leaf_index,
    input  logic signed [stws_pkg::RANK_W-1:0]   i_rank,
    input  logic signed [stws_pkg::AMT_W-1:0]    i_amount,
    output logic [stws_pkg::LEAF_W-1:0]          o_chosen_leaf,
    output logic signed [stws_pkg::DATA_W-1:0]   o_total
);
    import stws_pkg::*;

    // Node memory; the root lives in r_root, slot 0 is unused.
    logic [DATA_W-1:0] mem [TREE_DEPTH];

    logic [LVL_W-1:0]         r_levels;
    logic [KIND_W-1:0]        r_kind;
    logic [LEAF_W-1:0]        r_leaf_in;
    logic signed [RANK_W-1:0] r_rank;
    logic [DATA_W-1:0]        r_delta;
    logic [DATA_W-1:0]        r_root;
    logic [ADDR_W-1:0]        r_idx;
    logic [ADDR_W-1:0]        r_step;
    logic signed [PASS_W-1:0] r_passed;
    logic [LEAF_W-1:0]        r_path;
    logic [ADDR_W-1:0]        r_clr_addr;
    logic signed [DATA_W-1:0] r_rd_a;
    logic [DATA_W-1:0]        r_rd_b;

    logic [LVL_W-1:0]         lvl;
    logic [ADDR_W-1:0]        span;
    logic [DATA_W-1:0]        amt_ext;
    logic [ADDR_W-1:0]        half;
    logic signed [PASS_W-1:0] left_ext;
    logic signed [PASS_W-1:0] left_sum;
    logic signed [PASS_W-1:0] rank_ext;
    logic                     go_right;
    logic [ADDR_W-1:0]        child_idx;
    logic [DATA_W-1:0]        child_val;
    logic [ADDR_W-1:0]        n_idx;
    logic [ADDR_W-1:0]        n_step;
    logic [ADDR_W-1:0]        rd_addr_a;
    logic [ADDR_W-1:0]        rd_addr_b;
    logic                     wr_en;
    logic [ADDR_W-1:0]        wr_addr;
    logic [DATA_W-1:0]        wr_data;

    // Active depth saturates at the largest tree the memory holds.
    assign lvl     = (r_levels > LVL_W'(LEVEL_MAX)) ? LVL_W'(LEVEL_MAX) : r_levels;
    assign span    = ADDR_W'(1) << lvl;
    assign amt_ext = {{(DATA_W - AMT_W){i_amount[AMT_W-1]}}, i_amount};

    // One level of the walk: pick a child from the two sums read last cycle.
    assign half     = r_step >> 1;
    assign left_ext = {{(PASS_W - DATA_W){r_rd_a[DATA_W-1]}}, r_rd_a};
    assign left_sum = left_ext + r_passed;
    assign rank_ext = {{(PASS_W - RANK_W){r_rank[RANK_W-1]}}, r_rank};

    always_comb begin
        if (r_kind == KIND_TAKE) begin
            go_right = !(left_sum >= rank_ext);
        end else begin
            go_right = |(r_leaf_in & half[LEAF_W-1:0]);
        end
    end

    assign child_idx = go_right ? (r_idx + r_step) : (r_idx + ADDR_W'(1));
    assign child_val = go_right ? r_rd_b : r_rd_a;

    // Next node and span; the child reads are issued from these.
    always_comb begin
        if (i_cmd.accept) begin
            n_idx  = '0;
            n_step = span;
        end else if (i_cmd.step) begin
            n_idx  = child_idx;
            n_step = half;
        end else begin
            n_idx  = r_idx;
            n_step = r_step;
        end
    end

    assign rd_addr_a = n_idx + ADDR_W'(1);
    assign rd_addr_b = n_idx + n_step;

    // The write port serves both the walk update and the zeroing sweep.
    assign wr_en   = i_cmd.step | i_cmd.sweep;
    assign wr_addr = i_cmd.sweep ? r_clr_addr : child_idx;
    assign wr_data = i_cmd.sweep ? '0 : (child_val + r_delta);

    // Memory: one write port, two registered read ports.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd_a <= mem[rd_addr_a];
        r_rd_b <= mem[rd_addr_b];
    end

    // Configuration, root total and sweep address.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_levels   <= LVL_W'(LEVEL_MAX);
            r_root     <= '0;
            r_clr_addr <= '0;
        end else begin
            if (i_cfg_we) begin
                r_levels <= i_cfg_wdata;
            end
            if (i_cmd.accept) begin
                r_clr_addr <= '0;
                case (i_kind)
                    KIND_ADD:   r_root <= r_root + amt_ext;
                    KIND_TAKE:  r_root <= r_root - amt_ext;
                    KIND_CLEAR: r_root <= '0;
                    default:    r_root <= r_root;
                endcase
            end else if (i_cmd.sweep) begin
                r_clr_addr <= r_clr_addr + ADDR_W'(1);
            end
        end
    end

    // Item word and walk registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_kind    <= i_kind;
            r_leaf_in <= i_leaf_index;
            r_rank    <= i_rank;
            r_delta   <= (i_kind == KIND_TAKE) ? (DATA_W'(0) - amt_ext) : amt_ext;
            r_passed  <= '0;
            r_path    <= '0;
        end else if (i_cmd.step) begin
            r_path <= {r_path[LEAF_W-2:0], go_right};
            if (r_kind == KIND_TAKE && go_right) begin
                r_passed <= left_sum;
            end
        end
        r_idx  <= n_idx;
        r_step <= n_step;
    end

    assign o_sts.l_zero     = (lvl == '0);
    assign o_sts.walk_last  = (half == ADDR_W'(1));
    assign o_sts.sweep_last = &r_clr_addr;

    // Result word.
    always_comb begin
        case (r_kind)
            KIND_ADD:  o_chosen_leaf = r_leaf_in;
            KIND_TAKE: o_chosen_leaf = r_path;
            default:   o_chosen_leaf = '0;
        endcase
    end

    assign o_total = r_root;

endmodule

// ===== rtl/sum_tree_weighted_select.sv =====
// Weighted-selection sum tree: add, take by rank, clear; one result word per item.
// An add or take walks one tree level per cycle; o_done strobes after the last level.
// A clear sweeps all 2048 memory words. Other kinds and 0 levels go straight to o_done.
// Synchronous reset runs the same sweep with busy high; config writes still land.
// The receiver cannot stall; each result is shown for one cycle only.
module sum_tree_weighted_select (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [stws_pkg::KIND_W-1:0]          i_kind,
    input  logic [stws_pkg::LEAF_W-1:0]          i_leaf_index,
    input  logic signed [stws_pkg::RANK_W-1:0]   i_rank,
    input  logic signed [stws_pkg::AMT_W-1:0]    i_amount,
    input  logic                                 i_cfg_we,
    input  logic [stws_pkg::LVL_W-1:0]           i_cfg_wdata,
    output logic                                 o_done,
    output logic [stws_pkg::LEAF_W-1:0]          o_chosen_leaf,
    output logic signed [stws_pkg::DATA_W-1:0]  o_total
);
    import stws_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    // Sequencer.
    stws_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_kind  (i_kind),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .busy    (busy),
        .o_done  (o_done)
    );

    // Tree storage and walk arithmetic.
    stws_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_kind        (i_kind),
        .i_leaf_index  (i_leaf_index),
        .i_rank        (i_rank),
        .i_amount      (i_amount),
        .o_chosen_leaf (o_chosen_leaf),
        .o_total       (o_total)
    );

endmodule

// ===== rtl/stws_checker.sv =====
// Port-level checks for the weighted-selection sum tree, bound to the top level.
// Depends on stws_pkg for field widths and kind codes.
module stws_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 start,
    input logic                                 busy,
    input logic [stws_pkg::KIND_W-1:0]          i_kind,
    input logic                                 o_done,
    input logic [stws_pkg::LEAF_W-1:0]          o_chosen_leaf,
    input logic signed [stws_pkg::DATA_W-1:0]   o_total
);
    import stws_pkg::*;

    logic accept;
    assign accept = start && !busy;

    // A result word only appears while an item is in flight.
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> busy)
        else $error("result strobe without a word in flight");

    // Once the result word is out, the block takes new words again.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !busy)
        else $error("block still busy after its result");

    // A word of the unused kind answers at once with leaf zero.
    a_nop_quick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_kind != KIND_ADD && i_kind != KIND_TAKE && i_kind != KIND_CLEAR)
        |=> o_done && o_chosen_leaf == '0)
        else $error("unused kind not answered in one cycle");

    // A clear reports an empty tree.
    a_clear_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_kind == KIND_CLEAR) |=> o_total == '0)
        else $error("total not zero after clear");

endmodule

bind sum_tree_weighted_select stws_checker u_stws_checker (.*);
